FILE: rtl/core/sirs_pkg.sv
// shared constants, types and helpers of the radix symbol converter
`default_nettype none

package sirs_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_RADIX      = 32;
    localparam int SYMBOL_CAP     = 32;
    localparam int RADIX_LIMIT    = (MAX_RADIX < SYMBOL_CAP) ? MAX_RADIX : SYMBOL_CAP;

    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 5;
    localparam int SYM_W      = 8;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_BITS  = 8;
    localparam int SYMBOLS_W  = SYMBOL_CAP * SYM_W;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] SYM_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] SYM_CR    = 8'h0D;
    localparam logic [SYM_W-1:0] SYM_ERROR = 8'h00;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [CFG_W-1:0]   SYM_LOW_RESET = 64'h3736353433323130;
    localparam logic [CFG_W-1:0]   SYM_MID_RESET = 64'h0000000000003938;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIX    = 3'd0,
        REG_SYM_LOW  = 3'd1,
        REG_SYM_MID  = 3'd2,
        REG_SYM_HIGH = 3'd3,
        REG_SYM_TOP  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [RADIX_W-1:0]   radix;
        logic [SYMBOLS_W-1:0] symbols;
    } cfg_t;

    function automatic logic [SYM_W-1:0] symbol_of(
        input logic [SYMBOLS_W-1:0] symbols,
        input logic [DIGIT_W-1:0]   digit
    );
        return symbols[digit * SYM_W +: SYM_W];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sirs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sirs_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/sirs_front.sv
// configuration registers, alphabet check and input classification
`default_nettype none

module sirs_front #(
    parameter int VALUE_BITS = sirs_pkg::VALUE_BITS_DEF,
    parameter int IN_W       = ((VALUE_BITS + 7) / 8) * 8,
    parameter int ITEM_W     = VALUE_BITS + 2
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sirs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sirs_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [IN_W-1:0]                s_tdata,
    input  wire logic                           q_full,
    output logic                                q_push,
    output logic [ITEM_W-1:0]                   q_item,
    output sirs_pkg::cfg_t                      cfg
);

    typedef struct packed {
        logic                  bad;
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    sirs_pkg::cfg_t cfg_reg;
    logic                  bad_alpha;
    logic [VALUE_BITS-1:0] value;
    item_t                 item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radix   <= sirs_pkg::RADIX_RESET;
            cfg_reg.symbols <= {{(2 * sirs_pkg::CFG_W){1'b0}},
                                sirs_pkg::SYM_MID_RESET, sirs_pkg::SYM_LOW_RESET};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sirs_pkg::REG_RADIX:
                    cfg_reg.radix <= cfg_data[sirs_pkg::RADIX_W-1:0];
                sirs_pkg::REG_SYM_LOW:
                    cfg_reg.symbols[0 * sirs_pkg::CFG_W +: sirs_pkg::CFG_W] <= cfg_data;
                sirs_pkg::REG_SYM_MID:
                    cfg_reg.symbols[1 * sirs_pkg::CFG_W +: sirs_pkg::CFG_W] <= cfg_data;
                sirs_pkg::REG_SYM_HIGH:
                    cfg_reg.symbols[2 * sirs_pkg::CFG_W +: sirs_pkg::CFG_W] <= cfg_data;
                sirs_pkg::REG_SYM_TOP:
                    cfg_reg.symbols[3 * sirs_pkg::CFG_W +: sirs_pkg::CFG_W] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // the radix must lie in 2..32, and every symbol in use must not be NUL, whitespace or a sign, and must be unique
    always_comb
    begin
        logic [sirs_pkg::SYM_W-1:0] ci;
        logic [sirs_pkg::SYM_W-1:0] cj;
        logic                       sym_bad;
        bad_alpha = (cfg_reg.radix < sirs_pkg::RADIX_W'(2))
                 || (cfg_reg.radix > sirs_pkg::RADIX_W'(sirs_pkg::RADIX_LIMIT));
        for (int i = 0; i < sirs_pkg::SYMBOL_CAP; i++)
        begin
            ci = cfg_reg.symbols[i * sirs_pkg::SYM_W +: sirs_pkg::SYM_W];
            sym_bad = (ci == sirs_pkg::SYM_ERROR) || (ci == sirs_pkg::SYM_PLUS)
                   || (ci == sirs_pkg::SYM_MINUS) || (ci == sirs_pkg::SYM_SPACE)
                   || ((ci >= sirs_pkg::SYM_TAB) && (ci <= sirs_pkg::SYM_CR));
            for (int j = 0; j < i; j++)
            begin
                cj = cfg_reg.symbols[j * sirs_pkg::SYM_W +: sirs_pkg::SYM_W];
                if (cj == ci)
                begin
                    sym_bad = 1'b1;
                end
            end
            if (sym_bad && (sirs_pkg::RADIX_W'(i) < cfg_reg.radix))
            begin
                bad_alpha = 1'b1;
            end
        end
    end

    assign value    = s_tdata[VALUE_BITS-1:0];
    assign item.bad = bad_alpha;
    assign item.neg = value[VALUE_BITS-1];
    assign item.mag = value[VALUE_BITS-1] ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1})
                                          : value;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_item   = item;
    assign cfg      = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sirs_queue.sv
// two entry queue between the classifier and the converter
`default_nettype none

module sirs_queue #(
    parameter int WIDTH = 34
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head
);

    localparam int DEPTH = 2;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign full      = (count_reg == 2'(DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: rtl/core/sirs_back.sv
// digit generation by long division and most significant first emission
`default_nettype none

module sirs_back #(
    parameter int VALUE_BITS = sirs_pkg::VALUE_BITS_DEF,
    parameter int ITEM_W     = VALUE_BITS + 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sirs_pkg::cfg_t               cfg,
    input  wire logic                         q_valid,
    input  wire logic [ITEM_W-1:0]            q_item,
    output logic                              q_pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [sirs_pkg::SYM_W-1:0]        m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int STEPS    = (VALUE_BITS + sirs_pkg::STEP_BITS - 1) / sirs_pkg::STEP_BITS;
    localparam int PAD_BITS = STEPS * sirs_pkg::STEP_BITS;
    localparam int SW       = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW       = $clog2(VALUE_BITS);

    typedef struct packed {
        logic                  bad;
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_SIGN,
        ST_DIV,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                          state_reg;
    item_t                           item;
    logic [PAD_BITS-1:0]             quo_reg;
    logic [sirs_pkg::DIGIT_W-1:0]    rem_reg;
    logic [SW-1:0]                   step_reg;
    logic [AW-1:0]                   dig_reg;
    logic [AW-1:0]                   addr_reg;
    logic                            out_valid_reg;
    logic [sirs_pkg::SYM_W-1:0]      out_sym_reg;
    logic                            out_last_reg;
    logic                            out_user_reg;

    logic [PAD_BITS-1:0]             quo_next;
    logic [sirs_pkg::DIGIT_W-1:0]    rem_next;
    logic                            last_step;
    logic                            out_free;
    logic                            out_load;
    logic                            ram_we;
    logic [sirs_pkg::DIGIT_W-1:0]    ram_rdata;

    assign item = q_item;

    // eight restoring division steps per cycle
    always_comb
    begin
        logic [sirs_pkg::DIGIT_W:0] rr;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < sirs_pkg::STEP_BITS; k++)
        begin
            rr = {rem_next, quo_next[PAD_BITS-1]};
            if (rr >= cfg.radix)
            begin
                quo_next = {quo_next[PAD_BITS-2:0], 1'b1};
                rem_next = sirs_pkg::DIGIT_W'(rr - cfg.radix);
            end
            else
            begin
                quo_next = {quo_next[PAD_BITS-2:0], 1'b0};
                rem_next = rr[sirs_pkg::DIGIT_W-1:0];
            end
        end
    end

    assign last_step = (step_reg == SW'(STEPS - 1));
    assign out_free  = !out_valid_reg || m_tready;
    assign out_load  = out_free && ((state_reg == ST_ERR) || (state_reg == ST_SIGN)
                                    || (state_reg == ST_EMIT));
    assign ram_we    = (state_reg == ST_DIV) && last_step;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    sirs_ram #(
        .WIDTH (sirs_pkg::DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (dig_reg),
        .wdata (rem_next),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            dig_reg       <= '0;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_sym_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_user_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        quo_reg  <= PAD_BITS'(item.mag);
                        rem_reg  <= '0;
                        step_reg <= '0;
                        dig_reg  <= '0;
                        if (item.bad)
                        begin
                            state_reg <= ST_ERR;
                        end
                        else if (item.neg)
                        begin
                            state_reg <= ST_SIGN;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_ERR:
                begin
                    if (out_free)
                    begin
                        out_sym_reg   <= sirs_pkg::SYM_ERROR;
                        out_last_reg  <= 1'b1;
                        out_user_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_SIGN:
                begin
                    if (out_free)
                    begin
                        out_sym_reg   <= sirs_pkg::SYM_MINUS;
                        out_last_reg  <= 1'b0;
                        out_user_reg  <= 1'b0;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (last_step)
                    begin
                        quo_reg  <= quo_next;
                        rem_reg  <= '0;
                        step_reg <= '0;
                        dig_reg  <= dig_reg + AW'(1);
                        if ((quo_next == '0) || (dig_reg == AW'(VALUE_BITS - 1)))
                        begin
                            addr_reg  <= dig_reg;
                            state_reg <= ST_READ;
                        end
                    end
                    else
                    begin
                        quo_reg  <= quo_next;
                        rem_reg  <= rem_next;
                        step_reg <= step_reg + SW'(1);
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_sym_reg   <= sirs_pkg::symbol_of(cfg.symbols, ram_rdata);
                        out_last_reg  <= (addr_reg == '0);
                        out_user_reg  <= 1'b0;
                        if (addr_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            addr_reg  <= addr_reg - AW'(1);
                            state_reg <= ST_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

FILE: rtl/core/signed_integer_to_radix_symbols_top.sv
// top level of the signed integer to radix symbol converter
`default_nettype none

// Converts each signed VALUE_BITS-bit input into its symbols in the configured radix,
// most significant first, with a leading '-' for negative values and tlast on the final
// symbol. A radix outside 2..32 or an alphabet with a NUL, '+', '-', whitespace or
// repeated symbol among the digits in use gives one transaction with tdata 0, tuser 1
// and tlast 1. The input side classifies items and queues up to two of them, so it keeps
// accepting while a conversion runs, until the queue is full. The converter pops an item,
// emits a leading '-' when it is negative, then for each digit runs the long-division
// unit (eight quotient bits per cycle) over the whole quotient and writes the remainder
// to the digit memory; it then reads the digits back, most significant first, and emits
// them. Stalls on the output hold the emission of symbols. The digit memory needs no
// clearing after reset.
module signed_integer_to_radix_symbols_top #(
    parameter int VALUE_BITS = sirs_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [sirs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sirs_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,   // value
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [sirs_pkg::SYM_W-1:0]             m_tdata,   // symbol
    output logic                                   m_tlast,
    output logic                                   m_tuser    // bad_alphabet
);

    localparam int IN_W   = ((VALUE_BITS + 7) / 8) * 8;
    localparam int ITEM_W = VALUE_BITS + 2;

    sirs_pkg::cfg_t    cfg;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    logic [ITEM_W-1:0] q_in;
    logic [ITEM_W-1:0] q_head;

    sirs_front #(
        .VALUE_BITS (VALUE_BITS),
        .IN_W       (IN_W),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in),
        .cfg       (cfg)
    );

    sirs_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    sirs_back #(
        .VALUE_BITS (VALUE_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // an error transaction is a single, final one with a zero symbol
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == sirs_pkg::SYM_ERROR)))
        else $error("error transaction not final or nonzero");

    // the sign never ends a value
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser && (m_tdata == sirs_pkg::SYM_MINUS)) |-> !m_tlast)
        else $error("sign symbol marked last");

    // the queue is only popped when it holds an item
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire
